### sv/oaht_pkg.sv
// Package for the open addressing hash table core.
// Holds status codes, sequencer states and configuration constants.
package oaht_pkg;
  localparam int MAX_SLOTS_DEF = 64;
  localparam int SIZE_STEPS_DEF = 4;
  localparam int KEY_W = 31;
  localparam int ORD_W = 32;
  localparam int CFG_W = 7;
  localparam int CFG_REGS = 4;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REHASHED = 3'd2,
    ST_FOUND = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_RD, S_CHK, S_STEP, S_DONE,
    S_COL_RD, S_COL_CHK, S_CLR, S_RE_RD, S_RE_MOD
  } state_t;
endpackage

### sv/open_addressing_hash_table_core.sv
// Open addressing hash table core with triangular probing and rehash.
// Find and insert first run the key through the 31-step shared modulo unit, then probe
// slot by slot. A zero key is answered from the idle state without probing.
// A new beat is taken only in the idle state, and only once the previous result is taken.
// A rehash scans all MAX_SLOTS slots for valid entries, clears the table, then re-inserts
// each entry; each nested growth clears the table again and restarts its own re-insertions.
module open_addressing_hash_table_core
  import oaht_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int SIZE_STEPS = SIZE_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: key [30:0], entry_ord [62:31], zero [63]
  input  logic [63:0] s_axis_tdata,
  // tuser: mode [0]
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: status [2:0], slot [8:3], found_ord [40:9], probe_count [46:41], zero [47]
  output logic [47:0] m_axis_tdata
);
  localparam int AW = $clog2(MAX_SLOTS);
  localparam int MW = AW + 1;
  localparam int SW = (SIZE_STEPS > 1) ? $clog2(SIZE_STEPS) : 1;

  state_t state, state_next;
  logic [CFG_W-1:0] cfg_size [CFG_REGS];
  logic [MAX_SLOTS-1:0] vld;
  logic [KEY_W-1:0] keys [MAX_SLOTS];
  logic [ORD_W-1:0] ords [MAX_SLOTS];
  logic [KEY_W-1:0] spk [MAX_SLOTS];
  logic [ORD_W-1:0] spo [MAX_SLOTS];
  logic [KEY_W-1:0] rd_key;
  logic [ORD_W-1:0] rd_ord;
  logic rd_vld;

  logic mode, rehashing, lost;
  logic [KEY_W-1:0] key;
  logic [ORD_W-1:0] ord;
  logic [SW:0] step;
  logic [MW-1:0] m;
  logic [AW-1:0] pos;
  logic [MW-1:0] coll;
  logic [MW+KEY_W-1:0] rem;
  logic [5:0] bitc;
  logic [AW:0] idx, n, ri;
  logic [2:0] o_status;
  logic [5:0] o_slot, o_pc;
  logic [ORD_W-1:0] o_ord;

  function automatic logic [MW-1:0] size_of(input logic [CFG_W-1:0] v);
    logic [MW-1:0] r;
    if (v < 2) r = MW'(2);
    else if (32'(v) > MAX_SLOTS) r = MW'(MAX_SLOTS);
    else r = MW'(v);
    return r;
  endfunction

  logic [SW:0] cstep;
  logic [MW-1:0] m_cur;
  always_comb begin
    cstep = (32'(step) < CFG_REGS - 1) ? step : (SW+1)'(CFG_REGS - 1);
    m_cur = size_of(cfg_size[cstep[1:0]]);
  end

  logic last_step;
  assign last_step = 32'(step) + 1 >= SIZE_STEPS;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata = {1'b0, o_pc, o_ord, o_slot, o_status};

  // Shared restoring modulo unit and probe step.
  logic [MW+KEY_W-1:0] rem_sh;
  logic [MW:0] trial;
  logic [MW:0] pstep;
  always_comb begin
    rem_sh = {rem[MW+KEY_W-2:0], 1'b0};
    trial = {1'b0, rem_sh[MW+KEY_W-1:KEY_W]} - {1'b0, m};
    pstep = (MW+1)'(pos) + (MW+1)'(coll) + 1'b1;
    if (pstep >= (MW+1)'(m)) pstep = pstep - (MW+1)'(m);
  end

  logic hit, empty;
  assign empty = !rd_vld;
  assign hit = rd_vld && rd_key == key;

  logic half_ok, re_place, re_again, re_last, ins_grow;
  assign half_ok = 32'(coll) < 32'(m) / 2;
  assign re_place = !hit && (half_ok || (last_step && empty));
  assign re_again = !hit && !re_place && !last_step;
  assign re_last = 32'(ri) + 1 >= 32'(n);
  assign ins_grow = !mode && !hit && !half_ok && !last_step;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        state_next = (s_axis_tdata[KEY_W-1:0] == '0) ? S_IDLE : S_MOD;
      end
      S_MOD: if (bitc == 0) state_next = S_RD;
      S_RD: state_next = S_CHK;
      S_CHK: state_next = (empty || hit || coll + 1 >= m) ? S_DONE : S_STEP;
      S_STEP: state_next = S_RD;
      S_DONE: begin
        if (rehashing) begin
          if (re_again) state_next = S_CLR;
          else state_next = re_last ? S_IDLE : S_RE_RD;
        end else begin
          state_next = ins_grow ? S_COL_RD : S_IDLE;
        end
      end
      S_COL_RD: state_next = S_COL_CHK;
      S_COL_CHK: state_next = (idx == (AW+1)'(MAX_SLOTS - 1)) ? S_CLR : S_COL_RD;
      S_CLR: state_next = (n == 0) ? S_IDLE : S_RE_RD;
      S_RE_RD: state_next = S_RE_MOD;
      S_RE_MOD: if (bitc == 0) state_next = S_RD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == S_RD || state == S_COL_RD) begin
      rd_key <= keys[state == S_RD ? pos : idx[AW-1:0]];
      rd_ord <= ords[state == S_RD ? pos : idx[AW-1:0]];
      rd_vld <= vld[state == S_RD ? pos : idx[AW-1:0]];
    end
    if (state == S_COL_CHK && rd_vld) begin
      spk[n[AW-1:0]] <= rd_key;
      spo[n[AW-1:0]] <= rd_ord;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_size[0] <= 7'd11; cfg_size[1] <= 7'd19;
      cfg_size[2] <= 7'd29; cfg_size[3] <= 7'd37;
      vld <= '0;
      step <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) cfg_size[cfg_index] <= cfg_data;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          key <= s_axis_tdata[KEY_W-1:0];
          ord <= s_axis_tdata[KEY_W+ORD_W-1:KEY_W];
          mode <= s_axis_tuser;
          rehashing <= 1'b0;
          m <= m_cur;
          coll <= '0;
          rem <= {{MW{1'b0}}, s_axis_tdata[KEY_W-1:0]};
          bitc <= 6'(KEY_W);
          if (s_axis_tdata[KEY_W-1:0] == 0) begin
            m_axis_tvalid <= 1'b1;
            o_status <= s_axis_tuser ? ST_NOT_FOUND : ST_DUPLICATE;
            o_slot <= '0; o_pc <= '0; o_ord <= '0;
          end
        end
        S_MOD, S_RE_MOD: begin
          if (bitc != 0) begin
            bitc <= bitc - 1'b1;
            if (!trial[MW]) rem <= {trial[MW-1:0], rem_sh[KEY_W-1:1], 1'b1};
            else rem <= rem_sh;
          end else begin
            pos <= AW'(rem[MW+KEY_W-1:KEY_W]);
          end
        end
        S_STEP: begin
          coll <= coll + 1'b1;
          pos <= AW'(pstep);
        end
        S_CHK: if (empty || hit || coll + 1 >= m) begin
          if (!(empty || hit)) coll <= coll + 1'b1;
        end
        S_DONE: begin
          if (rehashing) begin
            if (re_place) begin
              vld[pos] <= 1'b1;
              keys[pos] <= key;
              ords[pos] <= ord;
            end
            if (re_again) step <= step + 1'b1;
            else if (!hit && !re_place) lost <= 1'b1;
            if (!re_again && re_last) begin
              m_axis_tvalid <= 1'b1;
              o_status <= (lost || (!hit && !re_place)) ? ST_FULL : ST_REHASHED;
            end
            ri <= ri + 1'b1;
          end else begin
            o_slot <= 6'(pos);
            o_pc <= (coll > 63) ? 6'd63 : 6'(coll);
            o_ord <= (mode && hit) ? rd_ord : '0;
            if (ins_grow) begin
              idx <= '0; n <= '0;
              step <= step + 1'b1;
              rehashing <= 1'b1;
              lost <= 1'b0;
            end else begin
              m_axis_tvalid <= 1'b1;
            end
            if (mode) o_status <= hit ? ST_FOUND : ST_NOT_FOUND;
            else if (hit) o_status <= ST_DUPLICATE;
            else if (half_ok) begin
              o_status <= ST_INSERTED;
              vld[pos] <= 1'b1; keys[pos] <= key; ords[pos] <= ord;
            end else if (last_step) o_status <= ST_FULL;
          end
        end
        S_COL_CHK: begin
          if (rd_vld) n <= n + 1'b1;
          idx <= (idx == (AW+1)'(MAX_SLOTS - 1)) ? '0 : idx + 1'b1;
        end
        S_CLR: begin
          vld <= '0;
          ri <= '0;
          lost <= 1'b0;
          m <= m_cur;
          if (n == 0) begin
            m_axis_tvalid <= 1'b1;
            o_status <= ST_REHASHED;
          end
        end
        S_RE_RD: begin
          coll <= '0;
          bitc <= 6'(KEY_W);
          key <= spk[ri[AW-1:0]];
          ord <= spo[ri[AW-1:0]];
          rem <= {{MW{1'b0}}, spk[ri[AW-1:0]]};
        end
        default: ;
      endcase
    end
  end
endmodule

### sim/oaht_checker.sv
// Checker for the open addressing hash table core: watches the config port and both streams.
// Keeps its own copy of the slot store, predicts every result beat and compares it.
// Depends on oaht_pkg for the status codes and the field widths.
`timescale 1ns / 100ps

module oaht_checker
  import oaht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic s_axis_tuser,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  output int errors,
  output int pending,
  output int results,
  output int rehashes,
  output int fulls,
  output int hits
);
  typedef struct packed {
    status_t status;
    logic [5:0] slot;
    logic [31:0] found_ord;
    logic [5:0] probe_count;
  } table_result_t;

  localparam int NSLOT = MAX_SLOTS_DEF;
  localparam int NSTEP = SIZE_STEPS_DEF;

  logic [KEY_W-1:0] tbl_key [NSLOT];
  logic [ORD_W-1:0] tbl_ord [NSLOT];
  logic [CFG_W-1:0] size_reg [CFG_REGS];
  int size_step;
  table_result_t expected_results [$];

  function automatic int size_at(int s);
    int v;
    v = size_reg[(s < 3) ? s : 3];
    if (v < 2) v = 2;
    if (v > NSLOT) v = NSLOT;
    return v;
  endfunction

  function automatic bit probe(logic [KEY_W-1:0] key, int m, output int pos, output int coll);
    int p;
    int c;
    p = int'({1'b0, key} % m);
    c = 0;
    while (tbl_key[p] != 0 && tbl_key[p] != key) begin
      c++;
      if (c < m) p = (p + c) % m;
      else break;
    end
    pos = p;
    coll = c;
    return tbl_key[p] == key;
  endfunction

  // Grows the table; returns 1 when an entry could not be placed.
  function automatic bit grow_table();
    logic [KEY_W-1:0] sk [NSLOT];
    logic [ORD_W-1:0] so [NSLOT];
    int n;
    int p;
    int c;
    int m;
    bit lost;
    bit again;
    n = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (tbl_key[i] != 0) begin
        sk[n] = tbl_key[i];
        so[n] = tbl_ord[i];
        n++;
      end
    end
    do begin
      size_step++;
      for (int i = 0; i < NSLOT; i++) tbl_key[i] = '0;
      lost = 0;
      again = 0;
      for (int i = 0; i < n; i++) begin
        m = size_at(size_step);
        if (probe(sk[i], m, p, c)) continue;
        if (c < m / 2 || (size_step + 1 >= NSTEP && tbl_key[p] == 0)) begin
          tbl_key[p] = sk[i];
          tbl_ord[p] = so[i];
        end else if (size_step + 1 < NSTEP) begin
          again = 1;
          break;
        end else begin
          lost = 1;
        end
      end
    end while (again);
    return lost;
  endfunction

  function automatic table_result_t lookup_or_insert(logic mode, logic [KEY_W-1:0] key,
                                                     logic [ORD_W-1:0] ord);
    table_result_t r;
    int m;
    int p;
    int c;
    bit hit;
    m = size_at(size_step);
    p = 0;
    c = 0;
    r.found_ord = '0;
    if (key == 0) begin
      r.status = mode ? ST_NOT_FOUND : ST_DUPLICATE;
    end else begin
      hit = probe(key, m, p, c);
      if (mode) begin
        if (hit) begin
          r.status = ST_FOUND;
          r.found_ord = tbl_ord[p];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end else if (hit) begin
        r.status = ST_DUPLICATE;
      end else if (c < m / 2) begin
        tbl_key[p] = key;
        tbl_ord[p] = ord;
        r.status = ST_INSERTED;
      end else if (size_step + 1 >= NSTEP) begin
        r.status = ST_FULL;
      end else begin
        r.status = grow_table() ? ST_FULL : ST_REHASHED;
      end
    end
    if (c > 63) c = 63;
    r.slot = p[5:0];
    r.probe_count = c[5:0];
    return r;
  endfunction

  assign pending = expected_results.size();

  initial begin
    errors = 0;
    results = 0;
    rehashes = 0;
    fulls = 0;
    hits = 0;
    size_step = 0;
    size_reg[0] = 7'd11;
    size_reg[1] = 7'd19;
    size_reg[2] = 7'd29;
    size_reg[3] = 7'd37;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_key[i] = '0;
      tbl_ord[i] = '0;
    end
  end

  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = table_result_t'({m_axis_tdata[2:0], m_axis_tdata[8:3], m_axis_tdata[40:9],
                               m_axis_tdata[46:41]});
        results++;
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
          end
          if (got.slot != want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, got.slot);
            errors++;
          end
          if (got.found_ord != want.found_ord) begin
            $error("found_ord: expected %h, actual %h", want.found_ord, got.found_ord);
            errors++;
          end
          if (got.probe_count != want.probe_count) begin
            $error("probe_count: expected %0d, actual %0d", want.probe_count,
                   got.probe_count);
            errors++;
          end
        end
      end
      if (cfg_we) size_reg[cfg_index] = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        want = lookup_or_insert(s_axis_tuser, s_axis_tdata[30:0], s_axis_tdata[62:31]);
        if (want.status == ST_REHASHED) rehashes++;
        if (want.status == ST_FULL) fulls++;
        if (want.status == ST_FOUND) hits++;
        expected_results.push_back(want);
      end
    end
  end
endmodule

### sim/tb.sv
// Top of the hash table testbench: clock, reset, config writes and request stimulus.
// Instantiates open_addressing_hash_table_core and oaht_checker, and reports the verdict.
`timescale 1ns / 100ps

module tb;
  import oaht_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [47:0] m_axis_tdata;
  int errors;
  int pending;
  int results;
  int rehashes;
  int fulls;
  int hits;
  int cycles;
  int sent;

  open_addressing_hash_table_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  oaht_checker i_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .errors(errors), .pending(pending), .results(results),
    .rehashes(rehashes), .fulls(fulls), .hits(hits)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver alternates between stretches of full speed, random stalls and long stalls.
  always @(negedge clk) begin
    int sel;
    if (rst) begin
      m_axis_tready <= 1'b1;
    end else begin
      sel = (cycles / 97) % 3;
      case (sel)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= ($urandom_range(0, 1) == 1);
        end
        default: begin
          m_axis_tready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  task automatic send_beat(logic mode, logic [30:0] key, logic [31:0] ord);
    bit taken;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {1'b0, ord, key};
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = s_axis_tready;
      @(negedge clk);
    end
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_size(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [30:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return 31'h7FFFFFFF;
    if (r < 60) return 31'($urandom_range(1, 150));
    if (r < 75) return 31'($urandom_range(1, 30) * 64 + $urandom_range(0, 3));
    return 31'($urandom);
  endfunction

  function automatic logic [31:0] pick_ord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h80000000;
    if (r == 1) return 32'h7FFFFFFF;
    if (r == 2) return 32'hFFFFFFFF;
    return $urandom;
  endfunction

  task automatic random_run(int count);
    int burst;
    for (int i = 0; i < count; i++) begin
      send_beat($urandom_range(0, 1), pick_key(), pick_ord());
      if (burst > 0) begin
        burst--;
      end else begin
        burst = $urandom_range(0, 12);
        if ($urandom_range(0, 2) != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk);
        end
      end
    end
  endtask

  initial begin
    cycles = 0;
    sent = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_beat(1'b0, 31'd0, 32'h12345678);
    send_beat(1'b1, 31'd0, 32'h0);
    send_beat(1'b1, 31'd5, 32'h0);
    send_beat(1'b0, 31'd5, 32'h7FFFFFFF);
    send_beat(1'b0, 31'd5, 32'h1);
    send_beat(1'b1, 31'd5, 32'h0);
    send_beat(1'b0, 31'd16, 32'h80000000);
    send_beat(1'b1, 31'd16, 32'hFFFFFFFF);
    send_beat(1'b0, 31'h7FFFFFFF, 32'hFFFFFFFF);
    send_beat(1'b1, 31'h7FFFFFFF, 32'h0);
    for (int k = 2; k < 9; k++) send_beat(1'b0, 31'(11 * k + 5), 32'(k));
    send_beat(1'b1, 31'd49, 32'h0);
    send_beat(1'b1, 31'd93, 32'h0);
    drain();

    // Tiny sizes force nested growth, the last one clamps to the largest table.
    write_size(2'd0, 7'd0);
    write_size(2'd1, 7'd1);
    write_size(2'd2, 7'd3);
    write_size(2'd3, 7'd127);
    for (int k = 0; k < 6; k++) send_beat(1'b0, 31'(11 * k + 3), $urandom);
    random_run(150);
    drain();
    random_run(150);
    drain();

    write_size(2'd3, 7'd2);
    random_run(150);
    drain();

    write_size(2'd0, 7'd64);
    write_size(2'd3, 7'd64);
    random_run(75);
    drain();

    $display("Sent %0d requests, checked %0d results: %0d hits, %0d growths, %0d full.",
             sent, results, hits, rehashes, fulls);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
